/* design/usv_pkg.sv */
// Package for the UTF-8 stream validator: word types and byte constants.
// Used by utf8_stream_validator; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package usv_pkg;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_stream;
	} byte_word_t;

	typedef struct packed {
		logic still_valid;
		logic end_of_stream_res;
	} verdict_word_t;

	localparam int unsigned REM_W = 3;
	localparam int unsigned ACC_W = 31;

	localparam logic [REM_W-1:0] MAX_REMAINING = 3'd5;

	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F8 = 8'hF8;
	localparam logic [7:0] LEAD_FC = 8'hFC;

	localparam logic [7:0] CONT_MIN_E0 = 8'hA0;
	localparam logic [7:0] CONT_MIN_F0 = 8'h90;
	localparam logic [7:0] CONT_MIN_F8 = 8'h88;
	localparam logic [7:0] CONT_MIN_FC = 8'h84;

	localparam logic [ACC_W-1:0] SURROGATE_MASK = 31'h7FFF_F800;
	localparam logic [ACC_W-1:0] SURROGATE_BASE = 31'h0000_D800;
	localparam logic [ACC_W-1:0] CODE_MAX       = 31'h0010_FFFF;

endpackage

`default_nettype wire

/* design/utf8_stream_validator.sv */
// UTF-8 stream validator: input register, per-byte check logic, result register.
// Depends on usv_pkg for the word types and constants.
// A byte word is held in the input register, and its verdict word is then written to the result register.
// Throughput: one byte word per cycle while the verdict output is not stalled, set by the state update loop.
// Reset clears the sequence state, the sticky flags and both valid flags at once.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_validator (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   byte_valid,
	output logic                  byte_stall,
	input  wire usv_pkg::byte_word_t byte_word,
	output logic                  verdict_valid,
	input  wire                   verdict_stall,
	output usv_pkg::verdict_word_t verdict_word
);

	logic                       valid_s1;
	usv_pkg::byte_word_t        word_s1;
	logic                       fire_s1;

	logic [usv_pkg::REM_W-1:0]  rem_q;
	logic [7:0]                 lead_q;
	logic [usv_pkg::ACC_W-1:0]  acc_q;
	logic                       failed_q;
	logic                       halted_q;

	logic [usv_pkg::REM_W-1:0]  rem_n;
	logic [7:0]                 lead_n;
	logic [usv_pkg::ACC_W-1:0]  acc_n;
	logic                       failed_n;
	logic                       halted_n;

	logic [7:0]                 c;
	logic                       lead_ok;
	logic [usv_pkg::REM_W-1:0]  lead_cnt;
	logic [usv_pkg::ACC_W-1:0]  lead_bits;
	logic                       cont_ok;
	logic [usv_pkg::ACC_W-1:0]  acc_shift;
	logic [usv_pkg::REM_W-1:0]  rem_dec;
	logic                       overlong;
	logic                       code_bad;

	assign fire_s1    = valid_s1 && !(verdict_valid && verdict_stall);
	assign byte_stall = valid_s1 && verdict_valid && verdict_stall;
	assign c          = word_s1.byte_in;

	always_comb begin
		lead_ok   = 1'b1;
		lead_cnt  = '0;
		lead_bits = '0;
		unique casez (c)
			8'b0???????: begin
				lead_cnt = 3'd0;
			end
			8'b110?????: begin
				lead_cnt  = 3'd1;
				lead_bits = {{(usv_pkg::ACC_W-5){1'b0}}, c[4:0]};
			end
			8'b1110????: begin
				lead_cnt  = 3'd2;
				lead_bits = {{(usv_pkg::ACC_W-4){1'b0}}, c[3:0]};
			end
			8'b11110???: begin
				lead_cnt  = 3'd3;
				lead_bits = {{(usv_pkg::ACC_W-3){1'b0}}, c[2:0]};
			end
			8'b111110??: begin
				lead_cnt  = 3'd4;
				lead_bits = {{(usv_pkg::ACC_W-2){1'b0}}, c[1:0]};
			end
			8'b1111110?: begin
				lead_cnt  = 3'd5;
				lead_bits = {{(usv_pkg::ACC_W-1){1'b0}}, c[0]};
			end
			default: begin
				lead_ok = 1'b0;
			end
		endcase
		if (lead_cnt == 3'd1 && c[4:1] == 4'd0) begin
			lead_ok = 1'b0;
		end
	end

	always_comb begin
		overlong = ((lead_q == usv_pkg::LEAD_E0) && (rem_q == 3'd2) && (c < usv_pkg::CONT_MIN_E0))
			|| ((lead_q == usv_pkg::LEAD_F0) && (rem_q == 3'd3) && (c < usv_pkg::CONT_MIN_F0))
			|| ((lead_q == usv_pkg::LEAD_F8) && (rem_q == 3'd4) && (c < usv_pkg::CONT_MIN_F8))
			|| ((lead_q == usv_pkg::LEAD_FC) && (rem_q == 3'd5) && (c < usv_pkg::CONT_MIN_FC));
		acc_shift = {acc_q[usv_pkg::ACC_W-7:0], c[5:0]};
		rem_dec   = rem_q - 3'd1;
		code_bad  = (acc_shift == '0)
			|| ((acc_shift & usv_pkg::SURROGATE_MASK) == usv_pkg::SURROGATE_BASE)
			|| (acc_shift > usv_pkg::CODE_MAX);
		cont_ok   = !overlong && (c[7:6] == 2'b10) && !((rem_dec == '0) && code_bad);
	end

	always_comb begin
		rem_n    = rem_q;
		lead_n   = lead_q;
		acc_n    = acc_q;
		failed_n = failed_q;
		halted_n = halted_q;
		if (!failed_q && !halted_q) begin
			priority if (c == 8'd0) begin
				halted_n = 1'b1;
			end else if (rem_q == '0 || rem_q > usv_pkg::MAX_REMAINING) begin
				if (lead_ok) begin
					rem_n  = lead_cnt;
					lead_n = c;
					acc_n  = lead_bits;
				end else begin
					failed_n = 1'b1;
				end
			end else begin
				if (cont_ok) begin
					rem_n = rem_dec;
					acc_n = acc_shift;
				end else begin
					failed_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			word_s1 <= byte_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			lead_q   <= '0;
			acc_q    <= '0;
			failed_q <= 1'b0;
			halted_q <= 1'b0;
		end else if (fire_s1) begin
			if (word_s1.end_of_stream) begin
				rem_q    <= '0;
				lead_q   <= '0;
				acc_q    <= '0;
				failed_q <= 1'b0;
				halted_q <= 1'b0;
			end else begin
				rem_q    <= rem_n;
				lead_q   <= lead_n;
				acc_q    <= acc_n;
				failed_q <= failed_n;
				halted_q <= halted_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid <= 1'b0;
		end else if (!(verdict_valid && verdict_stall)) begin
			verdict_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			verdict_word.still_valid       <= !failed_n;
			verdict_word.end_of_stream_res <= word_s1.end_of_stream;
		end
	end

`ifndef NO_ASSERTIONS
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= usv_pkg::MAX_REMAINING)
		else $error("continuation count out of range");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && word_s1.end_of_stream |=> rem_q == '0 && !failed_q && !halted_q)
		else $error("state not cleared after final word");

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && failed_q && !word_s1.end_of_stream |=> failed_q)
		else $error("failure flag dropped inside a stream");

	a_fail_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && failed_q |=> verdict_valid && !verdict_word.still_valid)
		else $error("failed stream reported as valid");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && verdict_valid)
		else $error("input stalled with free room");
`endif

endmodule

`default_nettype wire

/* sim/tb_utf8_stream_validator.sv */
// Self-checking testbench for utf8_stream_validator: directed, random and noise byte streams.
// Each accepted byte word is run through a local verdict predictor and checked in order.
// Depends on usv_pkg and on the utf8_stream_validator RTL.
`timescale 1ns / 1ps

module tb_utf8_stream_validator;

	localparam int TARGET_BYTES = 550;
	localparam int MAX_WAIT = 17;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	usv_pkg::byte_word_t byte_word;
	logic verdict_valid;
	logic verdict_stall;
	usv_pkg::verdict_word_t verdict_word;

	utf8_stream_validator dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_word(byte_word),
		.verdict_valid(verdict_valid),
		.verdict_stall(verdict_stall),
		.verdict_word(verdict_word)
	);

	logic [usv_pkg::REM_W-1:0] seq_pending;
	logic [7:0] seq_lead;
	logic [usv_pkg::ACC_W-1:0] seq_code;
	logic seq_failed;
	logic seq_halted;

	usv_pkg::verdict_word_t expected_verdicts[$];
	logic [7:0] stream_bytes[$];
	int bytes_sent;
	int mismatches;
	int sink_hold;
	bit src_quiet;
	bit sink_quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int draw_wait(input bit quiet);
		if (quiet || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(1, MAX_WAIT);
	endfunction

	function automatic void clear_sequence();
		seq_pending = '0;
		seq_lead = '0;
		seq_code = '0;
		seq_failed = 1'b0;
		seq_halted = 1'b0;
	endfunction

	function automatic void add_byte(input logic [7:0] data);
		stream_bytes = {stream_bytes, data};
	endfunction

	function automatic usv_pkg::verdict_word_t predict_verdict(input logic [7:0] data,
	                                                           input logic eos);
		usv_pkg::verdict_word_t v;
		logic bad;
		logic [usv_pkg::REM_W-1:0] n;
		logic [usv_pkg::ACC_W-1:0] payload;
		bad = 1'b0;
		n = '0;
		payload = '0;
		if (!seq_failed && !seq_halted) begin
			if (data == 8'h00) begin
				seq_halted = 1'b1;
			end else if (seq_pending == '0 || seq_pending > usv_pkg::MAX_REMAINING) begin
				casez (data)
					8'b0???????: n = 3'd0;
					8'b110?????: begin
						n = 3'd1;
						payload = {{(usv_pkg::ACC_W-5){1'b0}}, data[4:0]};
						bad = (data[4:1] == 4'b0000);
					end
					8'b1110????: begin
						n = 3'd2;
						payload = {{(usv_pkg::ACC_W-4){1'b0}}, data[3:0]};
					end
					8'b11110???: begin
						n = 3'd3;
						payload = {{(usv_pkg::ACC_W-3){1'b0}}, data[2:0]};
					end
					8'b111110??: begin
						n = 3'd4;
						payload = {{(usv_pkg::ACC_W-2){1'b0}}, data[1:0]};
					end
					8'b1111110?: begin
						n = 3'd5;
						payload = {{(usv_pkg::ACC_W-1){1'b0}}, data[0]};
					end
					default: bad = 1'b1;
				endcase
				if (!bad) begin
					seq_pending = n;
					seq_lead = data;
					seq_code = payload;
				end
			end else begin
				if ((seq_lead == usv_pkg::LEAD_E0 && seq_pending == 3'd2 &&
				     data < usv_pkg::CONT_MIN_E0) ||
				    (seq_lead == usv_pkg::LEAD_F0 && seq_pending == 3'd3 &&
				     data < usv_pkg::CONT_MIN_F0) ||
				    (seq_lead == usv_pkg::LEAD_F8 && seq_pending == 3'd4 &&
				     data < usv_pkg::CONT_MIN_F8) ||
				    (seq_lead == usv_pkg::LEAD_FC && seq_pending == 3'd5 &&
				     data < usv_pkg::CONT_MIN_FC)) begin
					bad = 1'b1;
				end else if (data[7:6] != 2'b10) begin
					bad = 1'b1;
				end else begin
					seq_code = {seq_code[usv_pkg::ACC_W-7:0], data[5:0]};
					seq_pending = seq_pending - 3'd1;
					if (seq_pending == '0)
						bad = (seq_code == '0) ||
						      ((seq_code & usv_pkg::SURROGATE_MASK) ==
						       usv_pkg::SURROGATE_BASE) ||
						      (seq_code > usv_pkg::CODE_MAX);
				end
			end
			if (bad)
				seq_failed = 1'b1;
		end
		v.still_valid = ~seq_failed;
		v.end_of_stream_res = eos;
		if (eos)
			clear_sequence();
		return v;
	endfunction

	task automatic send_byte(input logic [7:0] data, input logic eos);
		int gap;
		gap = draw_wait(src_quiet);
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_word <= {data, eos};
		do @(posedge clk); while (byte_stall !== 1'b0);
		expected_verdicts = {expected_verdicts, predict_verdict(data, eos)};
		bytes_sent++;
	endtask

	task automatic send_stream(input logic [7:0] seq[$]);
		foreach (seq[i])
			send_byte(seq[i], i == seq.size() - 1);
	endtask

	function automatic void append_code(input logic [usv_pkg::ACC_W-1:0] cp, input int n);
		logic [7:0] prefix;
		logic [usv_pkg::ACC_W-1:0] lead_bits;
		logic [usv_pkg::ACC_W-1:0] cont_bits;
		if (n == 1) begin
			add_byte({1'b0, cp[6:0]});
		end else begin
			prefix = 8'hFF << (8 - n);
			lead_bits = cp >> (6 * (n - 1));
			add_byte(prefix | lead_bits[7:0]);
			for (int k = n - 2; k >= 0; k--) begin
				cont_bits = cp >> (6 * k);
				add_byte({2'b10, cont_bits[5:0]});
			end
		end
	endfunction

	task automatic note_mismatch(input string what, input usv_pkg::verdict_word_t want,
	                             input usv_pkg::verdict_word_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected valid=%0b last=%0b, got valid=%0b last=%0b", $realtime,
			         what, want.still_valid, want.end_of_stream_res, got.still_valid,
			         got.end_of_stream_res);
	endtask

	always @(posedge clk) begin : verdict_sink
		usv_pkg::verdict_word_t want;
		if (!arst_n) begin
			sink_hold = 0;
			verdict_stall <= 1'b0;
		end else begin
			if (verdict_valid && !verdict_stall) begin
				if (expected_verdicts.size() == 0) begin
					note_mismatch("unexpected verdict", '0, verdict_word);
				end else begin
					want = expected_verdicts.pop_front();
					if (verdict_word.still_valid !== want.still_valid ||
					    verdict_word.end_of_stream_res !== want.end_of_stream_res)
						note_mismatch("verdict mismatch", want, verdict_word);
				end
				sink_hold = draw_wait(sink_quiet);
			end else if (sink_hold > 0) begin
				sink_hold--;
			end
			verdict_stall <= (sink_hold > 0);
		end
	end

	task automatic test_directed_cases();
		send_stream('{8'h41, 8'h7F});
		send_stream('{8'h80});
		send_stream('{8'hFF});
		send_stream('{8'hC1, 8'h80});
		send_stream('{8'hE0, 8'h9F});
		send_stream('{8'hF0, 8'h8F});
		send_stream('{8'hF8, 8'h87});
		send_stream('{8'hFC, 8'h83});
		send_stream('{8'hED, 8'hA0, 8'h80});
		send_stream('{8'hF4, 8'h90, 8'h80, 8'h80});
		send_stream('{8'hC2, 8'h41});
		send_stream('{8'h41, 8'h00, 8'hFF});
		send_stream('{8'hE2, 8'h82});
	endtask

	task automatic test_noise_streams();
		int len;
		repeat (12) begin
			src_quiet = ($urandom_range(0, 3) == 0);
			sink_quiet = ($urandom_range(0, 3) == 0);
			stream_bytes.delete();
			len = $urandom_range(1, 8);
			repeat (len) add_byte(8'($urandom_range(0, 255)));
			send_stream(stream_bytes);
		end
	endtask

	task automatic test_random_streams();
		int units;
		int kind;
		int n;
		int cut;
		bit clean;
		while (bytes_sent < TARGET_BYTES) begin
			src_quiet = ($urandom_range(0, 3) == 0);
			sink_quiet = ($urandom_range(0, 3) == 0);
			clean = ($urandom_range(0, 9) < 6);
			stream_bytes.delete();
			units = $urandom_range(1, 10);
			repeat (units) begin
				kind = clean ? $urandom_range(0, 13) : $urandom_range(0, 19);
				if (kind <= 5) begin
					append_code(31'($urandom_range(1, 8'h7F)), 1);
				end else if (kind <= 8) begin
					append_code(31'($urandom_range(32'h80, 32'h7FF)), 2);
				end else if (kind <= 11) begin
					append_code(31'($urandom_range(32'h800, 32'hFFFF)), 3);
				end else if (kind <= 13) begin
					append_code(31'($urandom_range(32'h1_0000, 32'h10_FFFF)), 4);
				end else if (kind == 14) begin
					if ($urandom_range(0, 1) == 0)
						append_code(31'($urandom_range(32'h11_0000, 32'h1F_FFFF)), 4);
					else
						append_code(31'($urandom_range(32'hD800, 32'hDFFF)), 3);
				end else if (kind == 15) begin
					if ($urandom_range(0, 1) == 0)
						append_code(31'($urandom_range(32'h20_0000, 32'h3FF_FFFF)), 5);
					else
						append_code(31'($urandom_range(32'h400_0000, 32'h7FFF_FFFF)), 6);
				end else if (kind == 16) begin
					append_code(31'($urandom_range(0, 8'h7F)), $urandom_range(2, 6));
				end else if (kind == 17) begin
					add_byte(8'($urandom_range(1, 255)));
				end else if (kind == 18 && $urandom_range(0, 1) == 0) begin
					add_byte(8'h00);
				end else begin
					n = $urandom_range(2, 4);
					append_code(31'($urandom_range(32'h80, 32'h10_FFFF) >> (6 * (4 - n))), n);
					cut = $urandom_range(1, n - 1);
					repeat (cut) void'(stream_bytes.pop_back());
				end
			end
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(2, 6);
				append_code(31'($urandom_range(32'h800, 32'h10_FFFF)), n);
				cut = $urandom_range(1, n - 1);
				repeat (cut) void'(stream_bytes.pop_back());
			end
			send_stream(stream_bytes);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_word <= '0;
		bytes_sent = 0;
		mismatches = 0;
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
		clear_sequence();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_noise_streams();
		test_random_streams();
		byte_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
